### rtl/bcs_pkg.sv
`timescale 1ns / 1ps
package bcs_pkg;

  localparam int unsigned MaxSlicesDef     = 1023;
  localparam int unsigned SpinupTicksDef   = 1000;
  localparam int unsigned PosToleranceDef  = 10;
  localparam int unsigned StopToleranceDef = 500;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_SPINUP     = 4'd1,
    PH_READY      = 4'd2,
    PH_RETRACT    = 4'd3,
    PH_TO_X       = 4'd4,
    PH_TO_START   = 4'd5,
    PH_CUTTING    = 4'd6,
    PH_RETRACTING = 4'd7,
    PH_PAUSED     = 4'd8,
    PH_DONE       = 4'd9,
    PH_ABORTED    = 4'd10
  } phase_e;

  typedef enum logic [3:0] {
    CMD_NONE        = 4'd0,
    CMD_MOVE_X      = 4'd1,
    CMD_MOVE_Y      = 4'd2,
    CMD_FEED_START  = 4'd3,
    CMD_FEED_PAUSE  = 4'd4,
    CMD_FEED_RESUME = 4'd5,
    CMD_FEED_ABORT  = 4'd6,
    CMD_SPIN_ON     = 4'd7,
    CMD_SPIN_OFF    = 4'd8
  } cmd_e;

  localparam logic [3:0] ACT_TICK    = 4'd0;
  localparam logic [3:0] ACT_START   = 4'd1;
  localparam logic [3:0] ACT_PAUSE   = 4'd2;
  localparam logic [3:0] ACT_RESUME  = 4'd3;
  localparam logic [3:0] ACT_ABORT   = 4'd4;
  localparam logic [3:0] ACT_RESET   = 4'd5;
  localparam logic [3:0] ACT_MAN_OFF = 4'd6;
  localparam logic [3:0] ACT_MAN_ON  = 4'd7;
  localparam logic [3:0] ACT_ZERO    = 4'd8;

  localparam logic [2:0] REG_STOCK_ZERO   = 3'd0;
  localparam logic [2:0] REG_SLICE_PITCH  = 3'd1;
  localparam logic [2:0] REG_TOTAL_SLICES = 3'd2;
  localparam logic [2:0] REG_BATCH_SIZE   = 3'd3;
  localparam logic [2:0] REG_Y_RETRACT    = 3'd4;
  localparam logic [2:0] REG_Y_CUT_START  = 3'd5;
  localparam logic [2:0] REG_Y_CUT_STOP   = 3'd6;
  localparam logic [2:0] REG_SPINDLE_AUTO = 3'd7;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] tgt;
  } beat_cmd_t;

  // one accepted item as registered at the input
  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] x_now;
    logic [31:0] y_now;
    logic        x_busy;
    logic        y_busy;
    logic        feed_active;
    logic        spindle_on;
    logic [9:0]  job_zero_value;
    logic [31:0] x_target;
    logic        x_over;
  } item_t;

  // all beats of one item, with shared status
  typedef struct packed {
    beat_cmd_t [2:0] cmds;
    logic [1:0]      n;
    logic [3:0]      phase;
    logic [9:0]      last_done;
    logic [9:0]      batch_done;
    logic            start_ok;
  } result_t;

endpackage

### rtl/bcs_out_queue.sv
`timescale 1ns / 1ps
module bcs_out_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  bcs_pkg::result_t  res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        command_o,
  output logic [31:0]       command_target_o,
  output logic [3:0]        phase_o,
  output logic [9:0]        last_done_o,
  output logic [9:0]        batch_done_o,
  output logic              start_ok_o,
  output logic              last_of_run_o
);

  bcs_pkg::result_t res_q;
  logic [1:0] idx_q, idx_d;
  logic       busy_q, busy_d;
  logic       take;
  logic       last_beat;

  assign take      = busy_q && !out_stall_i;
  assign last_beat = (idx_q == res_q.n - 2'd1);
  assign free_o    = !busy_q || (take && last_beat);

  // beat index within the held result
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (take) begin
      idx_d = idx_q + 2'd1;
      if (last_beat) begin
        busy_d = 1'b0;
      end
    end
    if (load_i) begin
      busy_d = 1'b1;
      idx_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o      = busy_q;
  assign command_o        = res_q.cmds[idx_q].cmd;
  assign command_target_o = res_q.cmds[idx_q].tgt;
  assign phase_o          = res_q.phase;
  assign last_done_o      = res_q.last_done;
  assign batch_done_o     = res_q.batch_done;
  assign start_ok_o       = res_q.start_ok;
  assign last_of_run_o    = last_beat;

endmodule

### rtl/batch_cut_sequencer.sv
`timescale 1ns / 1ps
// batch cut sequencer: one item is registered at the input, decided once the output
// register is free, and its one or two result beats leave from that output register
// throughput: one item per cycle when each item yields one beat and the output does
// not stall; an item with more beats holds the output until its last beat is taken
// reset: asynchronous active low for state and valid flags; item and result data have no reset
module batch_cut_sequencer #(
  parameter int unsigned SPINUP_TICKS  = bcs_pkg::SpinupTicksDef,
  parameter int unsigned POS_TOLERANCE = bcs_pkg::PosToleranceDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  action_i,
  input  logic [31:0] x_now_i,
  input  logic [31:0] y_now_i,
  input  logic        x_busy_i,
  input  logic        y_busy_i,
  input  logic        feed_active_i,
  input  logic        spindle_on_i,
  input  logic [9:0]  job_zero_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  command_o,
  output logic [31:0] command_target_o,
  output logic [3:0]  phase_o,
  output logic [9:0]  last_done_o,
  output logic [9:0]  batch_done_o,
  output logic        start_ok_o,
  output logic        last_of_run_o
);

  localparam int unsigned SpW = $clog2(SPINUP_TICKS + 1);
  localparam logic [SpW-1:0] SpinMax = SpW'(SPINUP_TICKS);

  // configuration
  logic signed [31:0] stock_zero_q, y_retract_q, y_cut_start_q, y_cut_stop_q;
  logic signed [23:0] slice_pitch_q;
  logic [9:0] total_slices_q, batch_size_q;
  logic       spindle_auto_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stock_zero_q <= '0; slice_pitch_q <= '0; total_slices_q <= '0;
      batch_size_q <= 10'd1; y_retract_q <= '0; y_cut_start_q <= '0;
      y_cut_stop_q <= '0; spindle_auto_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bcs_pkg::REG_STOCK_ZERO:   stock_zero_q   <= cfg_data_i;
        bcs_pkg::REG_SLICE_PITCH:  slice_pitch_q  <= cfg_data_i[23:0];
        bcs_pkg::REG_TOTAL_SLICES: total_slices_q <= cfg_data_i[9:0];
        bcs_pkg::REG_BATCH_SIZE:   batch_size_q   <= cfg_data_i[9:0];
        bcs_pkg::REG_Y_RETRACT:    y_retract_q    <= cfg_data_i;
        bcs_pkg::REG_Y_CUT_START:  y_cut_start_q  <= cfg_data_i;
        bcs_pkg::REG_Y_CUT_STOP:   y_cut_stop_q   <= cfg_data_i;
        bcs_pkg::REG_SPINDLE_AUTO: spindle_auto_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer state
  bcs_pkg::phase_e phase_q, phase_d, held_q, held_d;
  logic [9:0] slice_q, slice_d, compl_q, compl_d, bcnt_q, bcnt_d, blim_q, blim_d;
  logic [SpW-1:0] spin_q, spin_d;
  logic own_q, own_d, ovr_q, ovr_d;

  // input stage; the X target product is formed here from the state
  // that the item in the decision stage leaves
  bcs_pkg::item_t item_q;
  logic           item_vld_q;
  logic           in_take, dec_go, q_free;
  logic signed [34:0] xt_full;
  logic [9:0]     slice_next_src;
  logic [10:0]    nxt_w;

  assign in_stall_o = item_vld_q && !q_free;
  assign in_take    = in_valid_i && !in_stall_o;
  assign dec_go     = item_vld_q && q_free;

  assign slice_next_src = dec_go ? slice_d : slice_q;
  assign nxt_w   = {1'b0, slice_next_src} + 11'd1;
  assign xt_full = 35'(stock_zero_q) + 35'($signed({1'b0, nxt_w}) * slice_pitch_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_take) begin
      item_vld_q <= 1'b1;
    end else if (dec_go) begin
      item_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action         <= action_i;
      item_q.x_now          <= x_now_i;
      item_q.y_now          <= y_now_i;
      item_q.x_busy         <= x_busy_i;
      item_q.y_busy         <= y_busy_i;
      item_q.feed_active    <= feed_active_i;
      item_q.spindle_on     <= spindle_on_i;
      item_q.job_zero_value <= job_zero_value_i;
      item_q.x_over         <= (nxt_w > {1'b0, total_slices_q});
      if (xt_full > 35'sd2147483647) begin
        item_q.x_target <= 32'h7FFF_FFFF;
      end else if (xt_full < -35'sd2147483648) begin
        item_q.x_target <= 32'h8000_0000;
      end else begin
        item_q.x_target <= xt_full[31:0];
      end
    end
  end

  function automatic logic near(input logic [31:0] t, input logic [31:0] n);
    logic signed [32:0] d;
    d = $signed({t[31], t}) - $signed({n[31], n});
    if (d < 0) d = -d;
    return d <= 33'(POS_TOLERANCE);
  endfunction

  // decision logic
  bcs_pkg::result_t res;
  logic [9:0] remain, lim;

  always_comb begin
    phase_d = phase_q; held_d = held_q; slice_d = slice_q; compl_d = compl_q;
    bcnt_d = bcnt_q; blim_d = blim_q; spin_d = spin_q; own_d = own_q; ovr_d = ovr_q;
    res = '0;
    remain = total_slices_q - compl_q;
    lim = (batch_size_q == 10'd0) ? 10'd1 : batch_size_q;
    if (lim > remain) lim = remain;

    unique case (item_q.action)
      bcs_pkg::ACT_TICK: begin
        unique case (phase_q)
          bcs_pkg::PH_SPINUP: begin
            if (spin_q < SpinMax) spin_d = spin_q + SpW'(1);
            if (spin_d >= SpinMax) phase_d = bcs_pkg::PH_READY;
          end
          bcs_pkg::PH_READY: phase_d = bcs_pkg::PH_RETRACT;
          bcs_pkg::PH_RETRACT: begin
            if (near(y_retract_q, item_q.y_now)) begin
              phase_d = bcs_pkg::PH_TO_X;
            end else if (!item_q.y_busy) begin
              res.cmds[0] = '{bcs_pkg::CMD_MOVE_Y, y_retract_q};
              res.n = 2'd1;
            end
          end
          bcs_pkg::PH_TO_X: begin
            if (item_q.x_over) begin
              phase_d = bcs_pkg::PH_DONE;
            end else begin
              if (!item_q.x_busy) begin
                res.cmds[0] = '{bcs_pkg::CMD_MOVE_X, item_q.x_target};
                res.n = 2'd1;
              end
              if (near(item_q.x_target, item_q.x_now)) phase_d = bcs_pkg::PH_TO_START;
            end
          end
          bcs_pkg::PH_TO_START: begin
            if (!item_q.y_busy) begin
              res.cmds[0] = '{bcs_pkg::CMD_MOVE_Y, y_cut_start_q};
              res.n = 2'd1;
            end
            if (near(y_cut_start_q, item_q.y_now)) begin
              phase_d = bcs_pkg::PH_CUTTING;
              res.cmds[res.n] = '{bcs_pkg::CMD_FEED_START, y_cut_stop_q};
              res.n = res.n + 2'd1;
            end
          end
          bcs_pkg::PH_CUTTING: begin
            if (!item_q.feed_active) begin
              slice_d = slice_q + 10'd1;
              if (bcnt_q != 10'h3FF) bcnt_d = bcnt_q + 10'd1;
              compl_d = slice_d;
              phase_d = bcs_pkg::PH_RETRACTING;
            end
          end
          bcs_pkg::PH_RETRACTING: begin
            if (!item_q.y_busy) begin
              res.cmds[0] = '{bcs_pkg::CMD_MOVE_Y, y_retract_q};
              res.n = 2'd1;
            end
            if (near(y_retract_q, item_q.y_now)) begin
              if (bcnt_q >= blim_q || slice_q >= total_slices_q) begin
                if (spindle_auto_q && own_q && !ovr_q) begin
                  res.cmds[res.n] = '{bcs_pkg::CMD_SPIN_OFF, 32'd0};
                  res.n = res.n + 2'd1;
                  own_d = 1'b0;
                end
                phase_d = (bcnt_q >= blim_q) ? bcs_pkg::PH_IDLE : bcs_pkg::PH_DONE;
              end else begin
                phase_d = bcs_pkg::PH_TO_X;
              end
            end
          end
          default: ;
        endcase
      end
      bcs_pkg::ACT_START: begin
        if (phase_q == bcs_pkg::PH_IDLE && compl_q < total_slices_q) begin
          blim_d = lim; bcnt_d = '0; slice_d = compl_q; res.start_ok = 1'b1;
          if (spindle_auto_q) begin
            if (!item_q.spindle_on) begin
              res.cmds[0] = '{bcs_pkg::CMD_SPIN_ON, 32'd0};
              res.n = 2'd1; own_d = 1'b1; ovr_d = 1'b0;
            end else begin
              own_d = 1'b0;
            end
            phase_d = bcs_pkg::PH_SPINUP; spin_d = '0;
          end else begin
            phase_d = bcs_pkg::PH_RETRACT;
          end
        end
      end
      bcs_pkg::ACT_PAUSE: begin
        if (phase_q != bcs_pkg::PH_IDLE && phase_q != bcs_pkg::PH_DONE &&
            phase_q != bcs_pkg::PH_PAUSED && phase_q != bcs_pkg::PH_ABORTED) begin
          held_d = phase_q; phase_d = bcs_pkg::PH_PAUSED;
          if (item_q.feed_active) begin
            res.cmds[0] = '{bcs_pkg::CMD_FEED_PAUSE, 32'd0}; res.n = 2'd1;
          end
        end
      end
      bcs_pkg::ACT_RESUME: begin
        if (phase_q == bcs_pkg::PH_PAUSED) begin
          phase_d = held_q; held_d = bcs_pkg::PH_IDLE;
          if (held_q == bcs_pkg::PH_CUTTING) begin
            res.cmds[0] = '{bcs_pkg::CMD_FEED_RESUME, 32'd0}; res.n = 2'd1;
          end
          if (spindle_auto_q && !item_q.spindle_on) begin
            res.cmds[res.n] = '{bcs_pkg::CMD_SPIN_ON, 32'd0};
            res.n = res.n + 2'd1;
            own_d = 1'b1; ovr_d = 1'b0;
            phase_d = bcs_pkg::PH_SPINUP; spin_d = '0;
          end
        end
      end
      bcs_pkg::ACT_ABORT: begin
        if (spindle_auto_q && own_q && !ovr_q) begin
          res.cmds[0] = '{bcs_pkg::CMD_SPIN_OFF, 32'd0}; res.n = 2'd1; own_d = 1'b0;
        end
        phase_d = bcs_pkg::PH_ABORTED;
        res.cmds[res.n] = '{bcs_pkg::CMD_FEED_ABORT, 32'd0};
        res.n = res.n + 2'd1;
      end
      bcs_pkg::ACT_RESET: begin
        slice_d = '0; compl_d = '0; bcnt_d = '0; phase_d = bcs_pkg::PH_IDLE;
        own_d = 1'b0; ovr_d = 1'b0;
      end
      bcs_pkg::ACT_MAN_OFF: begin
        res.cmds[0] = '{bcs_pkg::CMD_SPIN_OFF, 32'd0}; res.n = 2'd1; ovr_d = 1'b1;
      end
      bcs_pkg::ACT_MAN_ON: begin
        res.cmds[0] = '{bcs_pkg::CMD_SPIN_ON, 32'd0}; res.n = 2'd1; ovr_d = 1'b1;
      end
      bcs_pkg::ACT_ZERO: compl_d = item_q.job_zero_value;
      default: ;
    endcase

    // an item without a command still gives one beat
    if (res.n == 2'd0) begin
      res.n = 2'd1;
    end
    res.phase      = phase_d;
    res.last_done  = compl_d;
    res.batch_done = bcnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bcs_pkg::PH_IDLE; held_q <= bcs_pkg::PH_IDLE;
      slice_q <= '0; compl_q <= '0; bcnt_q <= '0; blim_q <= 10'd1;
      spin_q <= '0; own_q <= 1'b0; ovr_q <= 1'b0;
    end else if (dec_go) begin
      phase_q <= phase_d; held_q <= held_d; slice_q <= slice_d; compl_q <= compl_d;
      bcnt_q <= bcnt_d; blim_q <= blim_d; spin_q <= spin_d; own_q <= own_d;
      ovr_q <= ovr_d;
    end
  end

  bcs_out_queue u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (dec_go),
    .res_i            (res),
    .free_o           (q_free),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .command_o        (command_o),
    .command_target_o (command_target_o),
    .phase_o          (phase_o),
    .last_done_o      (last_done_o),
    .batch_done_o     (batch_done_o),
    .start_ok_o       (start_ok_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

### rtl/bcs_checker.sv
`timescale 1ns / 1ps
module bcs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] command_o,
  input logic [3:0] phase_o,
  input logic       start_ok_o,
  input logic       last_of_run_o
);

  // a stalled beat holds its command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(command_o))
    else $error("stalled command beat changed");

  // abort feed always ends its run and leaves phase aborted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_o == bcs_pkg::CMD_FEED_ABORT |->
      last_of_run_o && phase_o == bcs_pkg::PH_ABORTED)
    else $error("abort feed not final or wrong phase");

  // a feed start beat means cutting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_o == bcs_pkg::CMD_FEED_START |-> phase_o == bcs_pkg::PH_CUTTING)
    else $error("feed start outside cutting");

  // an accepted start lands in spin-up or retract
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_ok_o |->
      phase_o == bcs_pkg::PH_SPINUP || phase_o == bcs_pkg::PH_RETRACT)
    else $error("start accepted with wrong phase");

endmodule

bind batch_cut_sequencer bcs_checker u_bcs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .command_o     (command_o),
  .phase_o       (phase_o),
  .start_ok_o    (start_ok_o),
  .last_of_run_o (last_of_run_o)
);

### dv/testbench.sv
`timescale 1ns / 1ps
module testbench;

  // one input beat as driven on the ports
  typedef struct {
    logic [3:0]  action;
    logic [31:0] x_now;
    logic [31:0] y_now;
    logic        x_busy;
    logic        y_busy;
    logic        feed_active;
    logic        spindle_on;
    logic [9:0]  job_zero;
  } cut_item_t;

  // one result beat
  typedef struct {
    logic [3:0]  cmd;
    logic [31:0] tgt;
    logic [3:0]  phase;
    logic [9:0]  last_done;
    logic [9:0]  batch_done;
    logic        start_ok;
    logic        fin;
  } cut_beat_t;

  // predicts the command beats of each item and checks the beats seen
  class cut_scoreboard;
    logic signed [31:0] stock_zero, y_retract, y_cut_start, y_cut_stop;
    logic signed [23:0] slice_pitch;
    logic [9:0]         total_slices, batch_size;
    logic               spindle_auto;

    logic [3:0] ph, held;
    int unsigned slice_idx, done_slice, batch_cnt, batch_lim, spin_cnt;
    bit started, manual;

    logic [3:0]  em_cmd[$];
    logic [31:0] em_tgt[$];
    cut_beat_t   cut_q[$];
    int          errors;

    function new();
      stock_zero = '0; slice_pitch = '0; total_slices = '0; batch_size = 10'd1;
      y_retract = '0; y_cut_start = '0; y_cut_stop = '0; spindle_auto = 1'b1;
      ph = bcs_pkg::PH_IDLE; held = bcs_pkg::PH_IDLE;
      slice_idx = 0; done_slice = 0; batch_cnt = 0; batch_lim = 1; spin_cnt = 0;
      started = 0; manual = 0; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        bcs_pkg::REG_STOCK_ZERO:   stock_zero = v;
        bcs_pkg::REG_SLICE_PITCH:  slice_pitch = v[23:0];
        bcs_pkg::REG_TOTAL_SLICES: total_slices = v[9:0];
        bcs_pkg::REG_BATCH_SIZE:   batch_size = v[9:0];
        bcs_pkg::REG_Y_RETRACT:    y_retract = v;
        bcs_pkg::REG_Y_CUT_START:  y_cut_start = v;
        bcs_pkg::REG_Y_CUT_STOP:   y_cut_stop = v;
        default:                   spindle_auto = v[0];
      endcase
    endfunction

    function int pending();
      return cut_q.size();
    endfunction

    // saturated x of the next slice
    function longint x_target();
      longint t;
      t = longint'(stock_zero) + longint'(slice_idx + 1) * longint'(slice_pitch);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      return t;
    endfunction

    function bit near(longint target, logic signed [31:0] now);
      longint d;
      d = target - longint'(now);
      if (d < 0) d = -d;
      return d <= 10;
    endfunction

    function void emit(logic [3:0] c, logic [31:0] t);
      if (em_cmd.size() < 3) begin
        em_cmd.insert(em_cmd.size(), c);
        em_tgt.insert(em_tgt.size(), t);
      end
    endfunction

    function void spin_start(logic on);
      if (!on) begin
        emit(bcs_pkg::CMD_SPIN_ON, 0);
        started = 1;
        manual = 0;
      end else begin
        started = 0;
      end
    endfunction

    function void spin_stop();
      if (spindle_auto && started && !manual) begin
        emit(bcs_pkg::CMD_SPIN_OFF, 0);
        started = 0;
      end
    endfunction

    function void do_tick(cut_item_t it);
      longint t;
      case (ph)
        bcs_pkg::PH_SPINUP: begin
          if (spin_cnt < 1000) spin_cnt++;
          if (spin_cnt >= 1000) ph = bcs_pkg::PH_READY;
        end
        bcs_pkg::PH_READY: ph = bcs_pkg::PH_RETRACT;
        bcs_pkg::PH_RETRACT: begin
          if (near(y_retract, it.y_now)) ph = bcs_pkg::PH_TO_X;
          else if (!it.y_busy) emit(bcs_pkg::CMD_MOVE_Y, y_retract);
        end
        bcs_pkg::PH_TO_X: begin
          if (slice_idx + 1 > total_slices) begin
            ph = bcs_pkg::PH_DONE;
          end else begin
            t = x_target();
            if (!it.x_busy) emit(bcs_pkg::CMD_MOVE_X, t[31:0]);
            if (near(t, it.x_now)) ph = bcs_pkg::PH_TO_START;
          end
        end
        bcs_pkg::PH_TO_START: begin
          if (!it.y_busy) emit(bcs_pkg::CMD_MOVE_Y, y_cut_start);
          if (near(y_cut_start, it.y_now)) begin
            ph = bcs_pkg::PH_CUTTING;
            emit(bcs_pkg::CMD_FEED_START, y_cut_stop);
          end
        end
        bcs_pkg::PH_CUTTING: begin
          if (!it.feed_active) begin
            slice_idx = (slice_idx + 1) & 1023;
            if (batch_cnt < 1023) batch_cnt++;
            done_slice = slice_idx;
            ph = bcs_pkg::PH_RETRACTING;
          end
        end
        bcs_pkg::PH_RETRACTING: begin
          if (!it.y_busy) emit(bcs_pkg::CMD_MOVE_Y, y_retract);
          if (near(y_retract, it.y_now)) begin
            if (batch_cnt >= batch_lim) begin
              spin_stop();
              ph = bcs_pkg::PH_IDLE;
            end else if (slice_idx >= total_slices) begin
              spin_stop();
              ph = bcs_pkg::PH_DONE;
            end else begin
              ph = bcs_pkg::PH_TO_X;
            end
          end
        end
        default: ;
      endcase
    endfunction

    // accepted input beat: work out its result beats
    function void note_item(cut_item_t it);
      bit ok;
      int unsigned lim;
      cut_beat_t b;
      ok = 0;
      em_cmd.delete();
      em_tgt.delete();
      case (it.action)
        bcs_pkg::ACT_TICK: do_tick(it);
        bcs_pkg::ACT_START: begin
          if (ph == bcs_pkg::PH_IDLE && done_slice < total_slices) begin
            lim = (batch_size < 1) ? 1 : batch_size;
            if (lim > total_slices - done_slice) lim = total_slices - done_slice;
            batch_lim = lim;
            batch_cnt = 0;
            slice_idx = done_slice;
            ok = 1;
            if (spindle_auto) begin
              spin_start(it.spindle_on);
              ph = bcs_pkg::PH_SPINUP;
              spin_cnt = 0;
            end else begin
              ph = bcs_pkg::PH_RETRACT;
            end
          end
        end
        bcs_pkg::ACT_PAUSE: begin
          if (ph != bcs_pkg::PH_IDLE && ph != bcs_pkg::PH_DONE &&
              ph != bcs_pkg::PH_PAUSED && ph != bcs_pkg::PH_ABORTED) begin
            held = ph;
            ph = bcs_pkg::PH_PAUSED;
            if (it.feed_active) emit(bcs_pkg::CMD_FEED_PAUSE, 0);
          end
        end
        bcs_pkg::ACT_RESUME: begin
          if (ph == bcs_pkg::PH_PAUSED) begin
            ph = held;
            held = bcs_pkg::PH_IDLE;
            if (ph == bcs_pkg::PH_CUTTING) emit(bcs_pkg::CMD_FEED_RESUME, 0);
            if (spindle_auto && !it.spindle_on) begin
              spin_start(it.spindle_on);
              ph = bcs_pkg::PH_SPINUP;
              spin_cnt = 0;
            end
          end
        end
        bcs_pkg::ACT_ABORT: begin
          spin_stop();
          ph = bcs_pkg::PH_ABORTED;
          emit(bcs_pkg::CMD_FEED_ABORT, 0);
        end
        bcs_pkg::ACT_RESET: begin
          slice_idx = 0; done_slice = 0; batch_cnt = 0;
          ph = bcs_pkg::PH_IDLE; started = 0; manual = 0;
        end
        bcs_pkg::ACT_MAN_OFF: begin
          emit(bcs_pkg::CMD_SPIN_OFF, 0);
          manual = 1;
        end
        bcs_pkg::ACT_MAN_ON: begin
          emit(bcs_pkg::CMD_SPIN_ON, 0);
          manual = 1;
        end
        bcs_pkg::ACT_ZERO: done_slice = it.job_zero;
        default: ;
      endcase
      if (em_cmd.size() == 0) emit(bcs_pkg::CMD_NONE, 0);
      foreach (em_cmd[k]) begin
        b.cmd = em_cmd[k];
        b.tgt = em_tgt[k];
        b.phase = ph;
        b.last_done = done_slice[9:0];
        b.batch_done = batch_cnt[9:0];
        b.start_ok = ok;
        b.fin = (k == em_cmd.size() - 1);
        cut_q.insert(cut_q.size(), b);
      end
    endfunction

    function void check_beat(cut_beat_t got);
      cut_beat_t e;
      if (cut_q.size() == 0) begin
        $error("result beat with nothing expected, command %0d", got.cmd);
        errors++;
        return;
      end
      e = cut_q.pop_front();
      if (got.cmd !== e.cmd) begin
        $error("command exp %0d got %0d", e.cmd, got.cmd); errors++;
      end
      if (got.tgt !== e.tgt) begin
        $error("command_target exp %0h got %0h", e.tgt, got.tgt); errors++;
      end
      if (got.phase !== e.phase) begin
        $error("phase exp %0d got %0d", e.phase, got.phase); errors++;
      end
      if (got.last_done !== e.last_done) begin
        $error("last_done exp %0d got %0d", e.last_done, got.last_done); errors++;
      end
      if (got.batch_done !== e.batch_done) begin
        $error("batch_done exp %0d got %0d", e.batch_done, got.batch_done); errors++;
      end
      if (got.start_ok !== e.start_ok) begin
        $error("start_ok exp %0d got %0d", e.start_ok, got.start_ok); errors++;
      end
      if (got.fin !== e.fin) begin
        $error("last_of_run exp %0d got %0d", e.fin, got.fin); errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [3:0]  action_i;
  logic [31:0] x_now_i;
  logic [31:0] y_now_i;
  logic        x_busy_i;
  logic        y_busy_i;
  logic        feed_active_i;
  logic        spindle_on_i;
  logic [9:0]  job_zero_value_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  command_o;
  logic [31:0] command_target_o;
  logic [3:0]  phase_o;
  logic [9:0]  last_done_o;
  logic [9:0]  batch_done_o;
  logic        start_ok_o;
  logic        last_of_run_o;

  cut_scoreboard sb;
  bit            calm;
  int            stall_left = 0;

  batch_cut_sequencer i_dut (.*);

  // clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // result side: check accepted beats, stall at random
  always @(posedge clk_i) begin
    cut_beat_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.cmd = command_o;
      got.tgt = command_target_o;
      got.phase = phase_o;
      got.last_done = last_done_o;
      got.batch_done = batch_done_o;
      got.start_ok = start_ok_o;
      got.fin = last_of_run_o;
      sb.check_beat(got);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) < 2) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // tick items get positions near the current goal most of the time
  function automatic cut_item_t make_item(logic [3:0] act);
    cut_item_t it;
    longint yg;
    it.action = act;
    it.x_now = $urandom;
    it.y_now = $urandom;
    it.x_busy = ($urandom_range(0, 9) < 3);
    it.y_busy = ($urandom_range(0, 9) < 3);
    it.feed_active = 1'($urandom_range(0, 1));
    it.spindle_on = 1'($urandom_range(0, 1));
    it.job_zero = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, sb.total_slices))
                                             : 10'($urandom_range(0, 1023));
    if (act == bcs_pkg::ACT_TICK && $urandom_range(0, 9) < 8) begin
      it.x_now = 32'(sb.x_target() + longint'($urandom_range(0, 20)) - 10);
      yg = (sb.ph == bcs_pkg::PH_TO_START) ? longint'(sb.y_cut_start)
                                           : longint'(sb.y_retract);
      it.y_now = 32'(yg + longint'($urandom_range(0, 22)) - 11);
    end
    return it;
  endfunction

  // action mix follows the predicted phase
  function automatic logic [3:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    case (sb.ph)
      bcs_pkg::PH_SPINUP: if (r < 97) return bcs_pkg::ACT_TICK;
      bcs_pkg::PH_IDLE: begin
        if (r < 40) return bcs_pkg::ACT_START;
        if (r < 48) return bcs_pkg::ACT_ZERO;
        if (r < 62) return bcs_pkg::ACT_TICK;
      end
      bcs_pkg::PH_PAUSED: begin
        if (r < 45) return bcs_pkg::ACT_RESUME;
        if (r < 70) return bcs_pkg::ACT_TICK;
      end
      bcs_pkg::PH_DONE, bcs_pkg::PH_ABORTED: begin
        if (r < 35) return bcs_pkg::ACT_RESET;
        if (r < 60) return bcs_pkg::ACT_TICK;
      end
      default: if (r < 84) return bcs_pkg::ACT_TICK;
    endcase
    r = $urandom_range(0, 9);
    case (r)
      0: return bcs_pkg::ACT_PAUSE;
      1: return bcs_pkg::ACT_ABORT;
      2: return bcs_pkg::ACT_RESET;
      3: return bcs_pkg::ACT_MAN_OFF;
      4: return bcs_pkg::ACT_MAN_ON;
      5: return bcs_pkg::ACT_ZERO;
      6: return bcs_pkg::ACT_START;
      7: return bcs_pkg::ACT_RESUME;
      8: return 4'($urandom_range(9, 15));
      default: return bcs_pkg::ACT_PAUSE;
    endcase
  endfunction

  // drive one beat, wait until it is taken, then idle for a random gap, possibly none
  task automatic send(cut_item_t it);
    int g;
    in_valid_i <= 1'b1;
    action_i <= it.action;
    x_now_i <= it.x_now;
    y_now_i <= it.y_now;
    x_busy_i <= it.x_busy;
    y_busy_i <= it.y_busy;
    feed_active_i <= it.feed_active;
    spindle_on_i <= it.spindle_on;
    job_zero_value_i <= it.job_zero;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(it);
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // hold the input until every expected beat is out, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [31:0] v[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= 3'(i);
      cfg_data_i <= v[i];
      sb.set_reg(3'(i), v[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // run timeout
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [31:0] cfg[8];
    logic [3:0]  plan[$];
    cut_item_t   it;
    sb = new();
    calm = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; action_i = '0; x_now_i = '0; y_now_i = '0;
    x_busy_i = 1'b0; y_busy_i = 1'b0; feed_active_i = 1'b0; spindle_on_i = 1'b0;
    job_zero_value_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: start and ticks toward a cut, pause in the feed, refused start, abort, reset
    cfg = '{32'd1000, 32'd500, 32'd3, 32'd2, 32'd0, -32'sd2000, -32'sd5000, 32'd0};
    write_regs(cfg);
    plan = '{bcs_pkg::ACT_START, bcs_pkg::ACT_TICK, bcs_pkg::ACT_TICK, bcs_pkg::ACT_TICK,
             bcs_pkg::ACT_PAUSE, bcs_pkg::ACT_RESUME, bcs_pkg::ACT_TICK, bcs_pkg::ACT_TICK,
             bcs_pkg::ACT_START, bcs_pkg::ACT_TICK, bcs_pkg::ACT_MAN_OFF,
             bcs_pkg::ACT_MAN_ON, bcs_pkg::ACT_ABORT, bcs_pkg::ACT_TICK,
             bcs_pkg::ACT_START, bcs_pkg::ACT_RESET, bcs_pkg::ACT_ZERO, bcs_pkg::ACT_START,
             bcs_pkg::ACT_ZERO, 4'd12, 4'd15};
    foreach (plan[k]) begin
      it = make_item(plan[k]);
      if (plan[k] == bcs_pkg::ACT_PAUSE) it.feed_active = 1'b1;
      if (plan[k] == bcs_pkg::ACT_ZERO) it.job_zero = (k < 17) ? 10'd1023 : 10'd0;
      send(it);
    end
    it = make_item(bcs_pkg::ACT_TICK);
    it.x_now = 32'h8000_0000; it.y_now = 32'h7fff_ffff;
    it.x_busy = 1; it.y_busy = 1; it.feed_active = 1; it.spindle_on = 1;
    it.job_zero = 10'd1023;
    send(it);
    drain();

    // random phases over several settings
    for (int p = 1; p < 8; p++) begin
      case (p)
        1: cfg = '{$urandom, $urandom, 32'd5, 32'd3, $urandom, $urandom, $urandom, 32'd0};
        2: cfg = '{32'h7fff_ffff, 32'h007f_ffff, 32'd1023, 32'd1023,
                   32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'd0};
        3: cfg = '{32'h8000_0000, 32'hff80_0000, 32'd2, 32'd1,
                   32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'd1};
        4: cfg = '{$urandom, $urandom, 32'd0, 32'd1, $urandom, $urandom, $urandom, 32'd0};
        5: cfg = '{$urandom, $urandom, $urandom_range(1, 6), $urandom_range(1, 4),
                   $urandom, $urandom, $urandom, 32'd1};
        default: cfg = '{$urandom, $urandom,
                         ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1023)
                                                     : $urandom_range(1, 8),
                         $urandom_range(0, 6), $urandom, $urandom, $urandom, 32'd0};
      endcase
      write_regs(cfg);
      calm = (p == 1);
      for (int n = 0; n < 65; n++) begin
        send(make_item(pick_action()));
        if (p == 2 && n == 30) drain();
      end
      drain();
    end

    calm = 1'b1;
    drain();
    if (sb.pending() != 0) begin
      $error("%0d result beats never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
